// File: hdl/kst_pkg.sv
package kst_pkg;

    localparam logic [7:0] SC_BACKSPACE  = 8'h0E;
    localparam logic [7:0] SC_ENTER      = 8'h1C;
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_CAPS_LOCK  = 8'h3A;
    localparam logic [7:0] SC_NUM_LOCK   = 8'h45;
    localparam logic [7:0] SC_SCRL_LOCK  = 8'h46;
    localparam logic [7:0] SC_ACK        = 8'hFA;
    localparam logic [7:0] SC_RESEND     = 8'hFE;

    localparam logic [7:0] CMD_SET_LEDS  = 8'hED;

    localparam logic [7:0] CH_BACKSPACE  = 8'h08;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_CASE_DIFF  = 8'h20;

    localparam logic [2:0] LED_CAPS      = 3'b100;
    localparam logic [2:0] LED_NUM       = 3'b010;
    localparam logic [2:0] LED_SCROLL    = 3'b001;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PW    = 2;
    localparam int RQ_CW    = 3;

    typedef struct packed {
        logic       kind;
        logic [7:0] code;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    entry0;
        result_t    entry1;
    } result_push_t;

    localparam logic [7:0] PLAIN_MAP [0:127] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h5E, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h40, 8'h5B, 8'h00, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
        8'h3A, 8'h00, 8'h00, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFTED_MAP [0:127] = '{
        8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h27, 8'h28, 8'h29, 8'h7E, 8'h2D, 8'h5E, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h60, 8'h7B, 8'h00, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h2B,
        8'h2A, 8'h00, 8'h00, 8'h7D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
    };

endpackage

// File: hdl/kst_front.sv
module kst_front #(
    parameter int CMD_QUEUE_DEPTH = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_wr_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [7:0]            scancode,
    output kst_pkg::result_push_t push
);
    import kst_pkg::*;

    localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(CMD_QUEUE_DEPTH);

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [CW-1:0] b);
        logic [SW-1:0] sum;
        sum = SW'(a) + SW'(b);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[PW-1:0];
    endfunction

    logic [1:0]    shift_held_reg, shift_held_next;
    logic [2:0]    lock_leds_reg, lock_leds_next;
    logic          awaiting_ack_reg, awaiting_ack_next;
    logic [7:0]    sent_byte_reg, sent_byte_next;
    logic [PW-1:0] cmd_head_reg, cmd_head_next;
    logic [CW-1:0] cmd_count_reg, cmd_count_next;
    logic [7:0]    cmd_queue_reg [CMD_QUEUE_DEPTH];

    logic          go;
    logic          shift_any;
    logic [7:0]    map_ch;
    logic [7:0]    ch;
    logic          char_valid;
    logic [2:0]    lock_bit;
    logic [2:0]    leds_new;
    logic          push_first;
    logic          push_second;
    logic [PW-1:0] pos0;
    logic [PW-1:0] pos1;
    logic          awaiting_mid;
    logic [CW-1:0] count_mid;
    logic          pop;
    logic [7:0]    pop_byte;
    logic          resend;
    logic          cmd_valid;
    logic [7:0]    cmd_byte;

    assign go = in_valid && in_ready;

    always_comb begin
        shift_any = shift_held_reg != 2'b00;
        if (scancode[7]) begin
            map_ch = 8'h00;
        end else if (shift_any) begin
            map_ch = SHIFTED_MAP[scancode[6:0]];
        end else begin
            map_ch = PLAIN_MAP[scancode[6:0]];
        end
        ch = map_ch;
        if ((map_ch inside {[CH_UPPER_A:CH_UPPER_Z]}) && (lock_leds_reg[2] == shift_any)) begin
            ch = map_ch + CH_CASE_DIFF;
        end
        if (scancode == SC_BACKSPACE) begin
            ch = CH_BACKSPACE;
        end else if (scancode == SC_ENTER) begin
            ch = CH_NEWLINE;
        end
        char_valid = ch != 8'h00;

        shift_held_next = shift_held_reg;
        lock_bit = 3'b000;
        case (scancode)
            SC_LSHIFT:     shift_held_next = shift_held_reg | 2'b01;
            SC_RSHIFT:     shift_held_next = shift_held_reg | 2'b10;
            SC_LSHIFT_BRK: shift_held_next = shift_held_reg & 2'b10;
            SC_RSHIFT_BRK: shift_held_next = shift_held_reg & 2'b01;
            SC_CAPS_LOCK:  lock_bit = LED_CAPS;
            SC_NUM_LOCK:   lock_bit = LED_NUM;
            SC_SCRL_LOCK:  lock_bit = LED_SCROLL;
            default:       lock_bit = 3'b000;
        endcase
        leds_new = lock_leds_reg ^ lock_bit;

        push_first  = (lock_bit != 3'b000) && (SW'(cmd_count_reg) < DEPTH_S);
        push_second = (lock_bit != 3'b000) && ((SW'(cmd_count_reg) + SW'(1)) < DEPTH_S);
        pos0 = wrap_add(cmd_head_reg, cmd_count_reg);
        pos1 = wrap_add(pos0, CW'(1));

        awaiting_mid = (scancode == SC_ACK) ? 1'b0 : awaiting_ack_reg;
        count_mid = cmd_count_reg + CW'(push_first) + CW'(push_second);
        pop = (count_mid != '0) && !awaiting_mid;
        pop_byte = (cmd_count_reg != '0) ? cmd_queue_reg[cmd_head_reg] : CMD_SET_LEDS;
        resend = (scancode == SC_RESEND) && awaiting_ack_reg;

        cmd_valid = resend || pop;
        cmd_byte = resend ? sent_byte_reg : pop_byte;

        push.entry0 = '{kind: KIND_CMD, code: cmd_byte, last: 1'b1};
        push.entry1 = '{kind: KIND_CMD, code: cmd_byte, last: 1'b1};
        if (char_valid) begin
            push.entry0 = '{kind: KIND_CHAR, code: ch, last: !cmd_valid};
        end
        if (!go) begin
            push.count = 2'd0;
        end else begin
            push.count = 2'(char_valid) + 2'(cmd_valid);
        end

        lock_leds_next    = leds_new;
        awaiting_ack_next = pop ? 1'b1 : awaiting_mid;
        sent_byte_next    = pop ? pop_byte : sent_byte_reg;
        cmd_head_next     = pop ? wrap_add(cmd_head_reg, CW'(1)) : cmd_head_reg;
        cmd_count_next    = count_mid - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_held_reg   <= 2'b00;
            lock_leds_reg    <= 3'b000;
            awaiting_ack_reg <= 1'b0;
            sent_byte_reg    <= 8'h00;
            cmd_head_reg     <= '0;
            cmd_count_reg    <= CW'(2);
        end else if (cfg_wr_en) begin
            lock_leds_reg    <= cfg_wr_data;
            awaiting_ack_reg <= 1'b0;
            cmd_head_reg     <= '0;
            cmd_count_reg    <= CW'(2);
        end else if (go) begin
            shift_held_reg   <= shift_held_next;
            lock_leds_reg    <= lock_leds_next;
            awaiting_ack_reg <= awaiting_ack_next;
            sent_byte_reg    <= sent_byte_next;
            cmd_head_reg     <= cmd_head_next;
            cmd_count_reg    <= cmd_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_queue_reg[0] <= CMD_SET_LEDS;
            cmd_queue_reg[1] <= 8'h00;
        end else if (cfg_wr_en) begin
            cmd_queue_reg[0] <= CMD_SET_LEDS;
            cmd_queue_reg[1] <= {5'b00000, cfg_wr_data};
        end else if (go) begin
            if (push_first) begin
                cmd_queue_reg[pos0] <= CMD_SET_LEDS;
            end
            if (push_second) begin
                cmd_queue_reg[pos1] <= {5'b00000, leds_new};
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        SW'(cmd_count_reg) <= DEPTH_S)
        else $error("command queue count beyond depth");

    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> !push.entry0.last && push.entry1.last
            && push.entry0.kind == KIND_CHAR && push.entry1.kind == KIND_CMD)
        else $error("two-result request badly ordered");

    a_ack_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        go && !cfg_wr_en && scancode == SC_ACK && cmd_count_reg == '0 |=> !awaiting_ack_reg)
        else $error("ack with empty queue left a wait pending");
`endif

endmodule

// File: hdl/kst_result_queue.sv
module kst_result_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kst_pkg::result_push_t push,
    output logic                  space_ok,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic [7:0]            m_code,
    output logic                  m_last
);
    import kst_pkg::*;

    result_t          rq_reg [RQ_DEPTH];
    logic [RQ_PW-1:0] head_reg, head_next;
    logic [RQ_PW-1:0] tail_reg, tail_next;
    logic [RQ_CW-1:0] count_reg, count_next;
    logic             pop;

    assign space_ok = count_reg <= RQ_CW'(RQ_DEPTH - 2);
    assign m_valid  = count_reg != '0;
    assign m_kind   = rq_reg[head_reg].kind;
    assign m_code   = rq_reg[head_reg].code;
    assign m_last   = rq_reg[head_reg].last;
    assign pop      = m_valid && m_ready;

    always_comb begin
        head_next  = head_reg + RQ_PW'(pop);
        tail_next  = tail_reg + RQ_PW'(push.count);
        count_next = count_reg + RQ_CW'(push.count) - RQ_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            rq_reg[tail_reg] <= push.entry0;
        end
        if (push.count == 2'd2) begin
            rq_reg[tail_reg + RQ_PW'(1)] <= push.entry1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> RQ_CW'(RQ_DEPTH) - count_reg >= RQ_CW'(push.count))
        else $error("result queue overflow");
`endif

endmodule

// File: hdl/keyboard_scancode_translator.sv
// Translates raw scan code set 1 bytes into character codes and keyboard command
// bytes. Each accepted scancode is decoded combinationally: shift and lock keys update
// their state, lock keys queue an LED command pair (0xED, LED byte), and at most one
// character plus one command byte come out, in that order, with m_last on the final
// one. Command bytes go out one at a time, each waiting for 0xFA; 0xFE repeats the
// byte in flight. A write on cfg_wr_en sets the lock LEDs and restarts the command
// queue with the LED pair; write only while idle. The block accepts one scancode per
// cycle while each yields at most one result and m_ready stays high; the two results
// of one scancode leave through the single output port one after the other, and
// s_ready drops while the four-entry result queue has fewer than two free slots.
// Command bytes that find the queue of CMD_QUEUE_DEPTH entries full are dropped.
module keyboard_scancode_translator #(
    parameter int CMD_QUEUE_DEPTH = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scancode,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_code,
    output logic       m_last
);
    import kst_pkg::*;

    result_push_t push;

    kst_front #(
        .CMD_QUEUE_DEPTH(CMD_QUEUE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .scancode   (s_scancode),
        .push       (push)
    );

    kst_result_queue u_result_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .space_ok(s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_kind  (m_kind),
        .m_code  (m_code),
        .m_last  (m_last)
    );

endmodule

// File: sim/keyboard_scancode_translator_test.sv
module keyboard_scancode_translator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import kst_pkg::*;

    localparam int CMD_DEPTH = 8;
    localparam int CMD_IW = $clog2(CMD_DEPTH);
    localparam int PHASE_ITEMS = 230;

    localparam logic [8*12-1:0] TOP_PLAIN = "1234567890-^";
    localparam logic [8*12-1:0] TOP_SHIFT = {"!", 8'h22, "#$%&", 8'h27, "()~-^"};
    localparam logic [8*12-1:0] ROW_Q_PLAIN = "QWERTYUIOP@[";
    localparam logic [8*12-1:0] ROW_Q_SHIFT = {"QWERTYUIOP", 8'h60, "{"};
    localparam logic [8*11-1:0] ROW_A_PLAIN = "ASDFGHJKL;:";
    localparam logic [8*11-1:0] ROW_A_SHIFT = "ASDFGHJKL+*";
    localparam logic [8*10-1:0] ROW_Z_PLAIN = "ZXCVBNM,./";
    localparam logic [8*10-1:0] ROW_Z_SHIFT = "ZXCVBNM<>?";
    localparam logic [8*13-1:0] KEYPAD = "789-456+1230.";

    typedef struct packed {
        logic       kind;
        logic [7:0] code;
        logic       last;
    } key_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [2:0] cfg_wr_data = 3'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_scancode = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_kind;
    logic [7:0] m_code;
    logic       m_last;

    logic       calm = 1'b0;
    int         errors = 0;
    int         sent_count = 0;

    logic [1:0] shift_state = 2'd0;
    logic [2:0] lock_state = 3'd0;
    logic       awaiting = 1'b0;
    logic [7:0] sent_cmd = 8'd0;
    logic [7:0] led_cmds [CMD_DEPTH];
    int         led_head = 0;
    int         led_count = 0;

    key_result_t pending_results[$];
    key_result_t got;
    key_result_t want;

    keyboard_scancode_translator #(
        .CMD_QUEUE_DEPTH(CMD_DEPTH)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_scancode(s_scancode),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_code(m_code),
        .m_last(m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 17);
    end

    function automatic logic [7:0] char_at(input logic [8*13-1:0] row, input int len,
                                           input int idx);
        return row[(len - 1 - idx) * 8 +: 8];
    endfunction

    function automatic logic [7:0] key_char(input logic [7:0] sc, input logic shifted);
        int i;
        i = int'(sc);
        if (i >= 'h02 && i <= 'h0D)
            return char_at(shifted ? TOP_SHIFT : TOP_PLAIN, 12, i - 'h02);
        if (i >= 'h10 && i <= 'h1B)
            return char_at(shifted ? ROW_Q_SHIFT : ROW_Q_PLAIN, 12, i - 'h10);
        if (i >= 'h1E && i <= 'h28)
            return char_at(shifted ? ROW_A_SHIFT : ROW_A_PLAIN, 11, i - 'h1E);
        if (i == 'h2B)
            return shifted ? 8'h7D : 8'h5D;
        if (i >= 'h2C && i <= 'h35)
            return char_at(shifted ? ROW_Z_SHIFT : ROW_Z_PLAIN, 10, i - 'h2C);
        if (i == 'h37)
            return 8'h2A;
        if (i == 'h39)
            return 8'h20;
        if (i >= 'h47 && i <= 'h53)
            return char_at(KEYPAD, 13, i - 'h47);
        if (i == 'h73)
            return shifted ? 8'h5F : 8'h5C;
        if (i == 'h7D)
            return shifted ? 8'h7C : 8'h5C;
        return 8'h00;
    endfunction

    function automatic void push_led_cmd(input logic [7:0] b);
        if (led_count < CMD_DEPTH) begin
            led_cmds[CMD_IW'((led_head + led_count) % CMD_DEPTH)] = b;
            led_count++;
        end
    endfunction

    function automatic void restart_leds(input logic [2:0] leds);
        lock_state = leds;
        awaiting = 1'b0;
        led_head = 0;
        led_count = 0;
        push_led_cmd(CMD_SET_LEDS);
        push_led_cmd({5'd0, leds});
    endfunction

    function automatic void predict_scancode(input logic [7:0] sc);
        logic [7:0] ch;
        logic [2:0] toggle;
        logic [8:0] outs [$];
        key_result_t r;
        int n;
        ch = 8'h00;
        toggle = 3'd0;
        n = 0;
        if (!sc[7]) begin
            ch = key_char(sc, shift_state != 2'd0);
            if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z
                && ((lock_state & LED_CAPS) != 3'd0) == (shift_state != 2'd0))
                ch = ch + CH_CASE_DIFF;
        end
        if (sc == SC_BACKSPACE)
            ch = CH_BACKSPACE;
        else if (sc == SC_ENTER)
            ch = CH_NEWLINE;
        if (ch != 8'h00) begin
            outs.push_back({KIND_CHAR, ch});
            n++;
        end
        if (sc == SC_LSHIFT) shift_state[0] = 1'b1;
        if (sc == SC_RSHIFT) shift_state[1] = 1'b1;
        if (sc == SC_LSHIFT_BRK) shift_state[0] = 1'b0;
        if (sc == SC_RSHIFT_BRK) shift_state[1] = 1'b0;
        if (sc == SC_CAPS_LOCK) toggle = LED_CAPS;
        if (sc == SC_NUM_LOCK) toggle = LED_NUM;
        if (sc == SC_SCRL_LOCK) toggle = LED_SCROLL;
        if (toggle != 3'd0) begin
            lock_state = lock_state ^ toggle;
            push_led_cmd(CMD_SET_LEDS);
            push_led_cmd({5'd0, lock_state});
        end
        if (sc == SC_ACK)
            awaiting = 1'b0;
        if (sc == SC_RESEND && awaiting) begin
            outs.push_back({KIND_CMD, sent_cmd});
            n++;
        end
        if (led_count > 0 && !awaiting) begin
            sent_cmd = led_cmds[CMD_IW'(led_head)];
            led_head = (led_head + 1) % CMD_DEPTH;
            led_count--;
            awaiting = 1'b1;
            outs.push_back({KIND_CMD, sent_cmd});
            n++;
        end
        for (int i = 0; i < n; i++) begin
            r.kind = outs[i][8];
            r.code = outs[i][7:0];
            r.last = (i == n - 1);
            pending_results.push_back(r);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_scancode(s_scancode);
            if (m_valid && m_ready) begin
                got.kind = m_kind;
                got.code = m_code;
                got.last = m_last;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: kind %0d code 0x%02h last %0d",
                           got.kind, got.code, got.last);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                        errors++;
                    end
                    if (got.code !== want.code) begin
                        $error("code: expected 0x%02h, actual 0x%02h", want.code, got.code);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send_scancode(input logic [7:0] sc);
        s_valid <= 1'b1;
        s_scancode <= sc;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent_count++;
        if (!calm && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_initial_leds(input logic [2:0] leds);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= leds;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        restart_leds(leds);
    endtask

    function automatic logic [7:0] random_lock_key();
        case ($urandom_range(2))
            0: return SC_CAPS_LOCK;
            1: return SC_NUM_LOCK;
            default: return SC_SCRL_LOCK;
        endcase
    endfunction

    task automatic send_typing(input int keys);
        logic [7:0] k;
        for (int i = 0; i < keys; i++) begin
            k = 8'($urandom_range(127));
            send_scancode(k);
            if ($urandom_range(9) < 7)
                send_scancode(k | 8'h80);
        end
    endtask

    task automatic send_random_sequence();
        logic [7:0] shift_make;
        logic [7:0] shift_break;
        case ($urandom_range(9))
            0, 1, 2, 3: send_typing($urandom_range(1, 6));
            4: begin
                shift_make = $urandom_range(1) ? SC_LSHIFT : SC_RSHIFT;
                shift_break = (shift_make == SC_LSHIFT) ? SC_LSHIFT_BRK : SC_RSHIFT_BRK;
                send_scancode(shift_make);
                if ($urandom_range(3) == 0)
                    send_scancode((shift_make == SC_LSHIFT) ? SC_RSHIFT : SC_LSHIFT);
                send_typing($urandom_range(1, 4));
                send_scancode(shift_break);
                if ($urandom_range(3) == 0)
                    send_scancode((shift_break == SC_LSHIFT_BRK) ? SC_RSHIFT_BRK
                                                                  : SC_LSHIFT_BRK);
            end
            5, 6: begin
                send_scancode(random_lock_key());
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(3) == 0)
                        send_scancode(SC_RESEND);
                    send_scancode(SC_ACK);
                end
            end
            7: begin
                repeat ($urandom_range(3, 6)) send_scancode(random_lock_key());
                repeat ($urandom_range(0, 8)) send_scancode(SC_ACK);
            end
            8: begin
                repeat ($urandom_range(1, 4))
                    send_scancode($urandom_range(1) ? SC_ACK : SC_RESEND);
            end
            default: begin
                repeat ($urandom_range(1, 4)) send_scancode(8'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic test_directed_keys();
        send_scancode(8'h1E);
        send_scancode(SC_RESEND);
        send_scancode(SC_ACK);
        send_scancode(SC_ACK);
        send_scancode(SC_RESEND);
        send_scancode(SC_LSHIFT);
        send_scancode(8'h10);
        send_scancode(SC_RSHIFT);
        send_scancode(SC_LSHIFT_BRK);
        send_scancode(8'h02);
        send_scancode(SC_RSHIFT_BRK);
        send_scancode(SC_CAPS_LOCK);
        send_scancode(SC_ACK);
        send_scancode(8'h10);
        send_scancode(SC_LSHIFT);
        send_scancode(8'h10);
        send_scancode(SC_LSHIFT_BRK);
        send_scancode(SC_ACK);
        send_scancode(SC_BACKSPACE);
        send_scancode(SC_ENTER);
        send_scancode(SC_NUM_LOCK);
        send_scancode(SC_SCRL_LOCK);
        send_scancode(SC_ACK);
        send_scancode(SC_ACK);
        send_scancode(SC_ACK);
        send_scancode(8'h00);
        send_scancode(8'hFF);
        wait_drained();
    endtask

    task automatic test_led_settings();
        logic [2:0] settings [$];
        int start;
        settings = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4};
        for (int p = 0; p < 8; p++) begin
            write_initial_leds(settings[p]);
            calm <= (p == 2);
            start = sent_count;
            while (sent_count - start < PHASE_ITEMS)
                send_random_sequence();
            wait_drained();
            calm <= 1'b0;
        end
    endtask

    initial begin
        int budget;
        restart_leds(3'd0);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_keys();
        test_led_settings();
        s_valid <= 1'b0;
        budget = 0;
        while (pending_results.size() != 0 && budget < 5000) begin
            @(posedge aclk);
            budget++;
        end
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
